@@ hdl/chain_crf_label_count_accumulator_defines.svh @@
// Assertion helpers used by the count accumulator back end.
// Every check is sampled on the rising clock edge and is off while reset is low.
`ifndef CHAIN_CRF_LABEL_COUNT_ACCUMULATOR_DEFINES_SVH
`define CHAIN_CRF_LABEL_COUNT_ACCUMULATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCLCA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CCLCA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cclca_pkg.sv @@
package cclca_pkg;

  // Default sizes of the count tables.
  localparam int unsigned DEF_MAX_STATES = 16;
  localparam int unsigned DEF_UNIT_ROWS  = 4096;
  localparam int unsigned DEF_COUNT_BITS = 32;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Fixed field widths of the words on the ports.
  localparam int unsigned ACTION_W      = 2;
  localparam int unsigned LABEL_W       = 4;
  localparam int unsigned OFFSET_W      = 12;
  localparam int unsigned VALUE_W       = 8;
  localparam int unsigned SEL_W         = 2;
  localparam int unsigned IN_ROW_W      = 12;
  localparam int unsigned IN_COL_W      = 4;
  localparam int unsigned RESULT_W      = 32;
  localparam int unsigned LABEL_LIMIT_W = 5;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_LABEL_LIMIT = '0;
  localparam logic [LABEL_LIMIT_W-1:0] LABEL_LIMIT_RST = LABEL_LIMIT_W'(16);

  // Action codes of an input word.
  localparam logic [ACTION_W-1:0] ACT_FEATURE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

  // Kind of work queued for the back end.
  typedef enum logic [1:0] {
    CMD_FEATURE = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_kind_e;

  // Table chosen by a read.
  typedef enum logic [SEL_W-1:0] {
    TBL_UNIT  = 2'd0,
    TBL_START = 2'd1,
    TBL_END   = 2'd2,
    TBL_TRANS = 2'd3
  } table_sel_e;

  // Classified command: which tables to bump, or what to read.
  typedef struct packed {
    cmd_kind_e  kind;
    logic       unit_en;
    logic       start_en;
    logic       trans_en;
    logic       end_en;
    table_sel_e sel;
    logic       rd_zero;
  } cmd_ctrl_t;

endpackage

@@ hdl/cclca_fifo.sv @@
module cclca_fifo
  import cclca_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && valid_o;

  // Pointers wrap at the depth; the count tracks occupancy.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hdl/cclca_front.sv @@
module cclca_front
  import cclca_pkg::*;
#(
  parameter int unsigned MAX_STATES = DEF_MAX_STATES,
  parameter int unsigned UNIT_ROWS  = DEF_UNIT_ROWS,
  localparam int unsigned ColW      = $clog2(MAX_STATES),
  localparam int unsigned RowW      = $clog2(UNIT_ROWS),
  localparam int unsigned UnitAw    = RowW + ColW,
  localparam int unsigned TransAw   = 2 * ColW
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [LABEL_LIMIT_W-1:0] label_limit_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ACTION_W-1:0]      action_i,
  input  logic [LABEL_W-1:0]       label_i,
  input  logic [OFFSET_W-1:0]      feature_offset_i,
  input  logic [VALUE_W-1:0]       feature_value_i,
  input  logic                     node_done_i,
  input  logic                     sequence_done_i,
  input  logic [SEL_W-1:0]         table_select_i,
  input  logic [IN_ROW_W-1:0]      read_row_i,
  input  logic [IN_COL_W-1:0]      read_col_i,
  input  logic                     clearing_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output cmd_ctrl_t                ctrl_o,
  output logic [UnitAw-1:0]        unit_addr_o,
  output logic [TransAw-1:0]       trans_addr_o,
  output logic [ColW-1:0]          col_o
);

  localparam int unsigned UrowW = OFFSET_W + 1;

  logic [LABEL_W-1:0] prev_label_q, prev_label_d;
  logic               have_prev_q, have_prev_d;
  logic               accept;
  logic               needed;
  logic               label_ok, prev_ok, col_ok;
  logic [UrowW-1:0]   unit_row;
  logic               unit_hit;

  // Words are taken whenever the queue has room and no clearing pass runs.
  assign in_ready_o = !q_full_i && !clearing_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && needed;

  // Label checks against the active number of states.
  assign label_ok = ({1'b0, label_i} < label_limit_i) && (int'(label_i) < MAX_STATES);
  assign prev_ok  = ({1'b0, prev_label_q} < label_limit_i) && (int'(prev_label_q) < MAX_STATES);
  assign col_ok   = (int'(read_col_i) < MAX_STATES);

  // Unit row of a feature level: offset plus level minus one.
  assign unit_row = UrowW'(feature_offset_i) + UrowW'(feature_value_i) - UrowW'(1);
  assign unit_hit = (feature_value_i != '0) && label_ok && (int'(unit_row) < UNIT_ROWS);

  // Classify the word into a command for the back end.
  always_comb begin
    ctrl_o       = '0;
    unit_addr_o  = '0;
    trans_addr_o = '0;
    col_o        = '0;
    needed       = 1'b0;
    case (action_i)
      ACT_FEATURE: begin
        ctrl_o.kind     = CMD_FEATURE;
        ctrl_o.unit_en  = unit_hit;
        ctrl_o.start_en = node_done_i && !have_prev_q && label_ok;
        ctrl_o.trans_en = node_done_i && have_prev_q && label_ok && prev_ok;
        ctrl_o.end_en   = node_done_i && sequence_done_i && label_ok;
        unit_addr_o     = {RowW'(unit_row), ColW'(label_i)};
        trans_addr_o    = {ColW'(prev_label_q), ColW'(label_i)};
        col_o           = ColW'(label_i);
        needed          = ctrl_o.unit_en || ctrl_o.start_en || ctrl_o.trans_en
                          || ctrl_o.end_en;
      end
      ACT_READ: begin
        ctrl_o.kind  = CMD_READ;
        ctrl_o.sel   = table_sel_e'(table_select_i);
        unit_addr_o  = {RowW'(read_row_i), ColW'(read_col_i)};
        trans_addr_o = {ColW'(read_row_i), ColW'(read_col_i)};
        col_o        = ColW'(read_col_i);
        needed       = 1'b1;
        case (table_sel_e'(table_select_i))
          TBL_UNIT:  ctrl_o.rd_zero = !(col_ok && (int'(read_row_i) < UNIT_ROWS));
          TBL_START: ctrl_o.rd_zero = !col_ok;
          TBL_END:   ctrl_o.rd_zero = !col_ok;
          TBL_TRANS: ctrl_o.rd_zero = !(col_ok && (int'(read_row_i) < MAX_STATES));
          default:   ctrl_o.rd_zero = 1'b1;
        endcase
      end
      ACT_CLEAR: begin
        ctrl_o.kind = CMD_CLEAR;
        needed      = 1'b1;
      end
      default: begin
        needed = 1'b0;
      end
    endcase
  end

  // Chain position: the last node of a sequence ends the chain.
  always_comb begin
    prev_label_d = prev_label_q;
    have_prev_d  = have_prev_q;
    if (accept && (action_i == ACT_FEATURE) && node_done_i) begin
      if (sequence_done_i) begin
        have_prev_d = 1'b0;
      end else begin
        prev_label_d = label_i;
        have_prev_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_label_q <= '0;
      have_prev_q  <= 1'b0;
    end else begin
      prev_label_q <= prev_label_d;
      have_prev_q  <= have_prev_d;
    end
  end

endmodule

@@ hdl/cclca_back.sv @@
`include "chain_crf_label_count_accumulator_defines.svh"

module cclca_back
  import cclca_pkg::*;
#(
  parameter int unsigned MAX_STATES = DEF_MAX_STATES,
  parameter int unsigned UNIT_ROWS  = DEF_UNIT_ROWS,
  parameter int unsigned COUNT_BITS = DEF_COUNT_BITS,
  localparam int unsigned ColW      = $clog2(MAX_STATES),
  localparam int unsigned RowW      = $clog2(UNIT_ROWS),
  localparam int unsigned UnitAw    = RowW + ColW,
  localparam int unsigned TransAw   = 2 * ColW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  cmd_ctrl_t           q_ctrl_i,
  input  logic [UnitAw-1:0]   q_unit_addr_i,
  input  logic [TransAw-1:0]  q_trans_addr_i,
  input  logic [ColW-1:0]     q_col_i,
  output logic                q_pop_o,
  output logic                clearing_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [RESULT_W-1:0] count_value_o
);

  localparam int unsigned UnitDepth  = UNIT_ROWS * (2 ** ColW);
  localparam int unsigned TransDepth = 2 ** TransAw;
  localparam int unsigned StDepth    = 2 ** ColW;
  localparam int unsigned SweepDepth = (UnitDepth > TransDepth) ? UnitDepth : TransDepth;
  localparam int unsigned SwW        = $clog2(SweepDepth);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_CLEAR = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;
  logic [SwW-1:0]      sweep_q, sweep_d;
  logic                out_valid_q, out_valid_d;
  logic [RESULT_W-1:0] out_data_q, out_data_d;
  cmd_ctrl_t           ctrl_q, ctrl_d;
  logic [UnitAw-1:0]   unit_addr_q, unit_addr_d;
  logic [TransAw-1:0]  trans_addr_q, trans_addr_d;
  logic [ColW-1:0]     col_q, col_d;

  logic [COUNT_BITS-1:0] unit_mem  [UnitDepth];
  logic [COUNT_BITS-1:0] trans_mem [TransDepth];
  logic [COUNT_BITS-1:0] start_mem [StDepth];
  logic [COUNT_BITS-1:0] end_mem   [StDepth];
  logic [COUNT_BITS-1:0] unit_rd_q, trans_rd_q, start_rd_q, end_rd_q;

  logic                  q_pop;
  logic                  clearing, exec_feat, sweep_last;
  logic                  unit_we, trans_we, start_we, end_we;
  logic [UnitAw-1:0]     unit_waddr;
  logic [TransAw-1:0]    trans_waddr;
  logic [ColW-1:0]       st_waddr;
  logic [COUNT_BITS-1:0] unit_wdata, trans_wdata, start_wdata, end_wdata;
  logic [COUNT_BITS-1:0] sel_cnt;
  logic [RESULT_W-1:0]   read_value;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  assign q_pop_o       = q_pop;
  assign clearing      = (state_q == ST_CLEAR);
  assign clearing_o    = clearing;
  assign exec_feat     = (state_q == ST_EXEC) && (ctrl_q.kind == CMD_FEATURE);
  assign sweep_last    = (sweep_q == SwW'(SweepDepth - 1));
  assign out_valid_o   = out_valid_q;
  assign count_value_o = out_data_q;

  // Select the count for a read; out-of-range entries read as zero.
  always_comb begin
    case (ctrl_q.sel)
      TBL_UNIT:  sel_cnt = unit_rd_q;
      TBL_START: sel_cnt = start_rd_q;
      TBL_END:   sel_cnt = end_rd_q;
      TBL_TRANS: sel_cnt = trans_rd_q;
      default:   sel_cnt = '0;
    endcase
    if (ctrl_q.rd_zero) begin
      sel_cnt = '0;
    end
  end

  // Fit the count into the result word, saturating when it is wider.
  if (COUNT_BITS > RESULT_W) begin : g_sat
    assign read_value = (|sel_cnt[COUNT_BITS-1:RESULT_W]) ? '1 : sel_cnt[RESULT_W-1:0];
  end else begin : g_ext
    assign read_value = RESULT_W'(sel_cnt);
  end

  // Sequencer: take a command, read the tables, then write back or answer; a clear runs the clearing pass.
  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    ctrl_d       = ctrl_q;
    unit_addr_d  = unit_addr_q;
    trans_addr_d = trans_addr_q;
    col_d        = col_q;
    q_pop        = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i && ((q_ctrl_i.kind != CMD_READ) || !out_valid_q || out_ready_i)) begin
          q_pop        = 1'b1;
          ctrl_d       = q_ctrl_i;
          unit_addr_d  = q_unit_addr_i;
          trans_addr_d = q_trans_addr_i;
          col_d        = q_col_i;
          if (q_ctrl_i.kind == CMD_CLEAR) begin
            state_d = ST_CLEAR;
            sweep_d = '0;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        if (ctrl_q.kind == CMD_READ) begin
          out_valid_d = 1'b1;
          out_data_d  = read_value;
        end
      end
      ST_CLEAR: begin
        if (sweep_last) begin
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + SwW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Command and result payload.
  always_ff @(posedge clk_i) begin
    ctrl_q       <= ctrl_d;
    unit_addr_q  <= unit_addr_d;
    trans_addr_q <= trans_addr_d;
    col_q        <= col_d;
    out_data_q   <= out_data_d;
  end

  // Write ports: zeros during the clearing pass, bumped counts otherwise.
  assign unit_we     = clearing ? (int'(sweep_q) < UnitDepth) : (exec_feat && ctrl_q.unit_en);
  assign trans_we    = clearing ? (int'(sweep_q) < TransDepth) : (exec_feat && ctrl_q.trans_en);
  assign start_we    = clearing ? (int'(sweep_q) < StDepth) : (exec_feat && ctrl_q.start_en);
  assign end_we      = clearing ? (int'(sweep_q) < StDepth) : (exec_feat && ctrl_q.end_en);
  assign unit_waddr  = clearing ? sweep_q[UnitAw-1:0] : unit_addr_q;
  assign trans_waddr = clearing ? sweep_q[TransAw-1:0] : trans_addr_q;
  assign st_waddr    = clearing ? sweep_q[ColW-1:0] : col_q;
  assign unit_wdata  = clearing ? '0 : sat_inc(unit_rd_q);
  assign trans_wdata = clearing ? '0 : sat_inc(trans_rd_q);
  assign start_wdata = clearing ? '0 : sat_inc(start_rd_q);
  assign end_wdata   = clearing ? '0 : sat_inc(end_rd_q);

  // Unit count table; read address comes from the queue head.
  always_ff @(posedge clk_i) begin
    if (unit_we) begin
      unit_mem[unit_waddr] <= unit_wdata;
    end
    unit_rd_q <= unit_mem[q_unit_addr_i];
  end

  // Transition count table.
  always_ff @(posedge clk_i) begin
    if (trans_we) begin
      trans_mem[trans_waddr] <= trans_wdata;
    end
    trans_rd_q <= trans_mem[q_trans_addr_i];
  end

  // Start count table.
  always_ff @(posedge clk_i) begin
    if (start_we) begin
      start_mem[st_waddr] <= start_wdata;
    end
    start_rd_q <= start_mem[q_col_i];
  end

  // End count table.
  always_ff @(posedge clk_i) begin
    if (end_we) begin
      end_mem[st_waddr] <= end_wdata;
    end
    end_rd_q <= end_mem[q_col_i];
  end

  // Checks on the sequencer.
  `CCLCA_ASSERT_IMP(a_read_slot_free, state_q == ST_EXEC && ctrl_q.kind == CMD_READ,
    !out_valid_q, "read result would overwrite a pending word")
  `CCLCA_ASSERT_NXT(a_read_gives_word, state_q == ST_EXEC && ctrl_q.kind == CMD_READ,
    out_valid_q, "read command produced no result word")
  `CCLCA_ASSERT_NXT(a_sweep_ends, state_q == ST_CLEAR && sweep_last,
    state_q == ST_IDLE, "clearing pass did not end after its last entry")
  `CCLCA_ASSERT_IMP(a_no_pop_busy, state_q != ST_IDLE,
    !q_pop, "command taken while the back end was busy")

endmodule

@@ hdl/chain_crf_label_count_accumulator.sv @@
// Linear-chain CRF empirical count accumulator. Feature words, reads and clears
// enter on the valid/ready input channel; a read answers with one word on the
// output channel, the other actions answer nothing. A front end classifies each
// word and tracks the previous label of the chain, then queues the work (two
// entries) for a back end that owns the four count tables. The back end reads the
// table memories as it pops a feature word or a read, then in its execute state
// writes the saturated increments or registers the result, since each table has a
// single read-modify-write path. Words that change nothing are dropped by the
// front end. After reset and after every clear action the back end runs a clearing
// pass over max(UNIT_ROWS * 2^ceil(log2(MAX_STATES)), 4^ceil(log2(MAX_STATES)))
// entries, 65536 with the default sizes, during which no input word is taken; the
// register port stays open. Register label_limit (offset 0) limits the labels in use
// and must be written only while the block is idle; the block does not enforce it.
module chain_crf_label_count_accumulator
  import cclca_pkg::*;
#(
  parameter int unsigned MAX_STATES = DEF_MAX_STATES,
  parameter int unsigned UNIT_ROWS  = DEF_UNIT_ROWS,
  parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [LABEL_W-1:0]    label_i,
  input  logic [OFFSET_W-1:0]   feature_offset_i,
  input  logic [VALUE_W-1:0]    feature_value_i,
  input  logic                  node_done_i,
  input  logic                  sequence_done_i,
  input  logic [SEL_W-1:0]      table_select_i,
  input  logic [IN_ROW_W-1:0]   read_row_i,
  input  logic [IN_COL_W-1:0]   read_col_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [RESULT_W-1:0]   count_value_o
);

  localparam int unsigned ColW    = $clog2(MAX_STATES);
  localparam int unsigned RowW    = $clog2(UNIT_ROWS);
  localparam int unsigned UnitAw  = RowW + ColW;
  localparam int unsigned TransAw = 2 * ColW;
  localparam int unsigned QW      = $bits(cmd_ctrl_t) + UnitAw + TransAw + ColW;

  logic [LABEL_LIMIT_W-1:0] label_limit_q;
  logic                     reg_hit, cfg_we;

  cmd_ctrl_t          f_ctrl, b_ctrl;
  logic [UnitAw-1:0]  f_unit_addr, b_unit_addr;
  logic [TransAw-1:0] f_trans_addr, b_trans_addr;
  logic [ColW-1:0]    f_col, b_col;
  logic [QW-1:0]      q_wdata, q_rdata;
  logic               q_push, q_full, q_valid, q_pop;
  logic               clearing;

  // Register port: one register, written in the access phase.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_LABEL_LIMIT);
  assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? APB_DATA_W'(label_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_limit_q <= LABEL_LIMIT_RST;
    end else if (cfg_we) begin
      label_limit_q <= pwdata[LABEL_LIMIT_W-1:0];
    end
  end

  cclca_front #(
    .MAX_STATES (MAX_STATES),
    .UNIT_ROWS  (UNIT_ROWS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .label_limit_i    (label_limit_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .label_i          (label_i),
    .feature_offset_i (feature_offset_i),
    .feature_value_i  (feature_value_i),
    .node_done_i      (node_done_i),
    .sequence_done_i  (sequence_done_i),
    .table_select_i   (table_select_i),
    .read_row_i       (read_row_i),
    .read_col_i       (read_col_i),
    .clearing_i       (clearing),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .ctrl_o           (f_ctrl),
    .unit_addr_o      (f_unit_addr),
    .trans_addr_o     (f_trans_addr),
    .col_o            (f_col)
  );

  // Command queue between the two ends.
  assign q_wdata = {f_ctrl, f_unit_addr, f_trans_addr, f_col};
  assign {b_ctrl, b_unit_addr, b_trans_addr, b_col} = q_rdata;

  cclca_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  cclca_back #(
    .MAX_STATES (MAX_STATES),
    .UNIT_ROWS  (UNIT_ROWS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_ctrl_i       (b_ctrl),
    .q_unit_addr_i  (b_unit_addr),
    .q_trans_addr_i (b_trans_addr),
    .q_col_i        (b_col),
    .q_pop_o        (q_pop),
    .clearing_o     (clearing),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .count_value_o  (count_value_o)
  );

endmodule

@@ tb/crf_count_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the count accumulator and the register port.
// Every accepted feature or clear word updates a private copy of the count tables.
// Every read word queues the count that it must return. Each returned word
// is compared with the oldest queued count.
module crf_count_checker
  import cclca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [LABEL_W-1:0]    label_i,
  input  logic [OFFSET_W-1:0]   feature_offset_i,
  input  logic [VALUE_W-1:0]    feature_value_i,
  input  logic                  node_done_i,
  input  logic                  sequence_done_i,
  input  logic [SEL_W-1:0]      table_select_i,
  input  logic [IN_ROW_W-1:0]   read_row_i,
  input  logic [IN_COL_W-1:0]   read_col_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [RESULT_W-1:0]   count_value_i,
  output int unsigned           errors_o,
  output int unsigned           pending_o
);

  localparam int unsigned STATES = DEF_MAX_STATES;
  localparam int unsigned ROWS   = DEF_UNIT_ROWS;
  localparam logic [RESULT_W-1:0] COUNT_TOP = '1;

  // Private copy of the count tables and of the chain state.
  logic [RESULT_W-1:0]      unit_tab [int unsigned];
  logic [RESULT_W-1:0]      start_tab [STATES];
  logic [RESULT_W-1:0]      end_tab [STATES];
  logic [RESULT_W-1:0]      trans_tab [STATES*STATES];
  logic [LABEL_W-1:0]       prev_label;
  bit                       chain_open;
  logic [LABEL_LIMIT_W-1:0] label_limit_q;

  // Counts that read words still owe, oldest first.
  logic [RESULT_W-1:0] expected_counts [$];
  int unsigned         mismatches;

  function automatic logic [RESULT_W-1:0] sat_up(logic [RESULT_W-1:0] c);
    return (c == COUNT_TOP) ? c : c + 1'b1;
  endfunction

  function automatic void wipe_tables();
    unit_tab.delete();
    foreach (start_tab[i]) start_tab[i] = '0;
    foreach (end_tab[i]) end_tab[i] = '0;
    foreach (trans_tab[i]) trans_tab[i] = '0;
  endfunction

  // Applies one accepted input word to the table copy.
  function automatic void apply_word();
    int unsigned         ns;
    int unsigned         row;
    int unsigned         key;
    bit                  ok;
    logic [RESULT_W-1:0] got;
    case (action_i)
      ACT_READ: begin
        got = '0;
        key = int'(read_row_i) * STATES + int'(read_col_i);
        case (table_sel_e'(table_select_i))
          TBL_UNIT: if (read_row_i < ROWS && unit_tab.exists(key)) got = unit_tab[key];
          TBL_START: got = start_tab[read_col_i];
          TBL_END: got = end_tab[read_col_i];
          default: if (read_row_i < STATES) got = trans_tab[key];
        endcase
        expected_counts.push_back(got);
      end
      ACT_CLEAR: begin
        wipe_tables();
      end
      ACT_FEATURE: begin
        ns = (label_limit_q > STATES) ? STATES : int'(label_limit_q);
        ok = label_i < ns;
        // Unit count at offset plus level minus one, unless the row is past the table.
        if (feature_value_i != '0 && ok) begin
          row = int'(feature_offset_i) + int'(feature_value_i) - 1;
          if (row < ROWS) begin
            key = row * STATES + int'(label_i);
            unit_tab[key] = sat_up(unit_tab.exists(key) ? unit_tab[key] : '0);
          end
        end
        // Node completion: start or transition, then end of sequence.
        if (node_done_i) begin
          if (!chain_open) begin
            if (ok) start_tab[label_i] = sat_up(start_tab[label_i]);
          end else if (ok && prev_label < ns) begin
            key = int'(prev_label) * STATES + int'(label_i);
            trans_tab[key] = sat_up(trans_tab[key]);
          end
          if (sequence_done_i) begin
            if (ok) end_tab[label_i] = sat_up(end_tab[label_i]);
            chain_open = 1'b0;
          end else begin
            prev_label = label_i;
            chain_open = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [RESULT_W-1:0] want;
    if (!rst_ni) begin
      wipe_tables();
      prev_label = '0;
      chain_open = 1'b0;
      label_limit_q = LABEL_LIMIT_RST;
      expected_counts.delete();
      mismatches = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      // A returned word is always for an earlier read, so compare it first.
      if (out_valid_i && out_ready_i) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: count word arrived with none expected, expected none, actual %0d",
                   $time, count_value_i);
          mismatches++;
        end else begin
          want = expected_counts.pop_front();
          if (want !== count_value_i) begin
            $display("%0t: count_value mismatch, expected %0d, actual %0d",
                     $time, want, count_value_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) apply_word();
      // Register writes land after any word taken at the same edge.
      if (psel && penable && pwrite && pready &&
          paddr[APB_ADDR_W-1:2] == REG_LABEL_LIMIT) begin
        label_limit_q = pwdata[LABEL_LIMIT_W-1:0];
      end
      errors_o <= mismatches;
      pending_o <= expected_counts.size();
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import cclca_pkg::*;

  localparam logic [ACTION_W-1:0]   ACT_SPARE        = 2'd3;
  localparam logic [APB_ADDR_W-1:0] ADDR_LABEL_LIMIT = {REG_LABEL_LIMIT, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED    = {~REG_LABEL_LIMIT, 2'b00};
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned PHASE_WORDS  = 140;

  // One input word, field by field.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [LABEL_W-1:0]  label;
    logic [OFFSET_W-1:0] offset;
    logic [VALUE_W-1:0]  level;
    logic                node_done;
    logic                seq_done;
    logic [SEL_W-1:0]    sel;
    logic [IN_ROW_W-1:0] row;
    logic [IN_COL_W-1:0] col;
  } word_t;

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  psel             = 1'b0;
  logic                  penable          = 1'b0;
  logic                  pwrite           = 1'b0;
  logic [APB_ADDR_W-1:0] paddr            = '0;
  logic [APB_DATA_W-1:0] pwdata           = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i       = 1'b0;
  logic                  in_ready_o;
  logic [ACTION_W-1:0]   action_i         = '0;
  logic [LABEL_W-1:0]    label_i          = '0;
  logic [OFFSET_W-1:0]   feature_offset_i = '0;
  logic [VALUE_W-1:0]    feature_value_i  = '0;
  logic                  node_done_i      = 1'b0;
  logic                  sequence_done_i  = 1'b0;
  logic [SEL_W-1:0]      table_select_i   = '0;
  logic [IN_ROW_W-1:0]   read_row_i       = '0;
  logic [IN_COL_W-1:0]   read_col_i       = '0;
  logic                  out_valid_o;
  logic                  out_ready_i      = 1'b0;
  logic [RESULT_W-1:0]   count_value_o;

  int unsigned errors;
  int unsigned pending;
  int unsigned cycles    = 0;
  int unsigned send_calm = 0;
  int unsigned recv_calm = 0;
  bit          hold_request = 1'b0;

  chain_crf_label_count_accumulator uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .action_i, .label_i, .feature_offset_i,
    .feature_value_i, .node_done_i, .sequence_done_i, .table_select_i,
    .read_row_i, .read_col_i, .out_valid_o, .out_ready_i, .count_value_o
  );

  crf_count_checker chk (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid_i, .in_ready_i(in_ready_o), .action_i, .label_i, .feature_offset_i,
    .feature_value_i, .node_done_i, .sequence_done_i, .table_select_i,
    .read_row_i, .read_col_i, .out_valid_i(out_valid_o), .out_ready_i,
    .count_value_i(count_value_o), .errors_o(errors), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Wait before the next word, drawn at random, with stretches of no wait.
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 8);
  endfunction

  function automatic word_t feat(int unsigned lbl, int unsigned off, int unsigned lvl,
                                 bit nd, bit sd);
    word_t w;
    w = word_t'($bits(word_t)'({$urandom(), $urandom()}));
    w.action = ACT_FEATURE;
    w.label = LABEL_W'(lbl);
    w.offset = OFFSET_W'(off);
    w.level = VALUE_W'(lvl);
    w.node_done = nd;
    w.seq_done = sd;
    return w;
  endfunction

  function automatic word_t rd(table_sel_e sel, int unsigned row, int unsigned col);
    word_t w;
    w = word_t'($bits(word_t)'({$urandom(), $urandom()}));
    w.action = ACT_READ;
    w.sel = sel;
    w.row = IN_ROW_W'(row);
    w.col = IN_COL_W'(col);
    return w;
  endfunction

  // Offers one word and returns at the edge where it is taken.
  task automatic put_word(input word_t w);
    int unsigned gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= w.action;
    label_i <= w.label;
    feature_offset_i <= w.offset;
    feature_value_i <= w.level;
    node_done_i <= w.node_done;
    sequence_done_i <= w.seq_done;
    table_select_i <= w.sel;
    read_row_i <= w.row;
    read_col_i <= w.col;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops offering and waits until every read has been answered and the block is quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Setup phase and access phase, then an idle bus so that writes never abut.
  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random traffic: mostly labelled sequences followed by reads of what they touched,
  // the rest broken sequences and words with every field random.
  task automatic run_phase(input int unsigned words, input bit with_clear);
    int unsigned sent;
    int unsigned clear_at;
    int unsigned base;
    int unsigned nodes;
    int unsigned entries;
    int unsigned lbl;
    int unsigned pick;
    table_sel_e  sel;
    word_t       w;
    sent = 0;
    base = 0;
    clear_at = $urandom_range(words / 4, 3 * words / 4);
    while (sent < words) begin
      if (with_clear && sent >= clear_at) begin
        w = rd(TBL_UNIT, 0, 0);
        w.action = ACT_CLEAR;
        put_word(w);
        with_clear = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        base = $urandom_range(0, 40);
        nodes = $urandom_range(1, 5);
        for (int n = 0; n < nodes; n++) begin
          lbl = $urandom_range(0, 15);
          entries = $urandom_range(1, 3);
          for (int e = 0; e < entries; e++) begin
            put_word(feat(lbl, base + $urandom_range(0, 4), $urandom_range(0, 4),
                          e == entries - 1, n == nodes - 1 && e == entries - 1));
            sent++;
          end
        end
        repeat ($urandom_range(1, 3)) begin
          sel = table_sel_e'($urandom_range(0, 3));
          put_word(rd(sel, (sel == TBL_UNIT) ? base + $urandom_range(0, 8)
                                             : $urandom_range(0, 17),
                      $urandom_range(0, 15)));
          sent++;
        end
      end else if (pick < 80) begin
        // Broken sequence: flags in any combination, labels changing inside a node.
        repeat ($urandom_range(1, 3)) begin
          put_word(feat($urandom_range(0, 15), base + $urandom_range(0, 4),
                        $urandom_range(0, 4), $urandom_range(0, 1), $urandom_range(0, 1)));
          sent++;
        end
      end else begin
        w = word_t'($bits(word_t)'({$urandom(), $urandom()}));
        if (w.action == ACT_CLEAR) w.action = ACT_READ;
        put_word(w);
        if (w.action != ACT_SPARE) sent++;
      end
    end
  endtask

  // Receiver: random stall per word, plus one long hold-off on request.
  initial begin : receiver
    int unsigned stall;
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    word_t       plan [$];
    int unsigned phase_states [6];
    phase_states = '{16, 1, 0, 31, 5, 17};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_reg(ADDR_LABEL_LIMIT, 16);

    // Directed: table edges, absent level, flags, unused action and reads of each table.
    plan = '{
      feat(0, 0, 1, 0, 0),
      feat(15, 4095, 1, 0, 0),
      feat(3, 4095, 2, 0, 0),
      feat(15, 4000, 255, 1, 0),
      feat(2, 7, 0, 1, 0),
      feat(7, 10, 3, 0, 1),
      feat(7, 10, 3, 1, 1),
      rd(TBL_UNIT, 0, 0),
      rd(TBL_UNIT, 4095, 15),
      rd(TBL_UNIT, 12, 7),
      rd(TBL_START, 0, 15),
      rd(TBL_END, 4095, 7),
      rd(TBL_TRANS, 15, 2),
      rd(TBL_TRANS, 2, 7),
      rd(TBL_TRANS, 4095, 15),
      rd(TBL_TRANS, 16, 0)
    };
    plan[0].action = ACT_SPARE;
    plan.push_back(feat(0, 0, 1, 0, 0));
    foreach (plan[i]) put_word(plan[i]);
    settle();

    // Few labels in use: an invalid label blocks the next transition.
    write_reg(ADDR_LABEL_LIMIT, 4);
    plan = '{
      feat(9, 0, 1, 1, 0),
      feat(1, 0, 1, 1, 1),
      rd(TBL_END, 0, 1),
      rd(TBL_START, 0, 9),
      rd(TBL_UNIT, 0, 9),
      rd(TBL_TRANS, 9, 1),
      rd(TBL_TRANS, 0, 0),
      rd(TBL_UNIT, 0, 0),
      rd(TBL_END, 0, 7)
    };
    plan[6].action = ACT_CLEAR;
    foreach (plan[i]) put_word(plan[i]);
    settle();

    // Random phases, each under its own label count.
    for (int p = 0; p < 6; p++) begin
      if (p == 2) write_reg(ADDR_UNMAPPED, 3);
      write_reg(ADDR_LABEL_LIMIT, phase_states[p]);
      if (p == 0) begin
        hold_request = 1'b1;
        send_calm = 40;
      end
      run_phase(PHASE_WORDS, p % 2 == 1);
      settle();
    end

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
